// ===== src/acrr_pkg.sv =====
// ----------------------------------------------------------------------------
// ADC round-robin converter package
// Shared types and constants for the channel phase logic, the job queue and
// the conversion back end.
// ----------------------------------------------------------------------------
package acrr_pkg;

	typedef enum logic [2:0] {
		PH_CAPTURE = 3'd0,
		PH_TEMP    = 3'd1,
		PH_SUPPLY  = 3'd2,
		PH_CORE    = 3'd3,
		PH_REF     = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_MUL,
		B_NUM,
		B_PREP,
		B_DIV,
		B_ROUND,
		B_EMIT
	} back_state_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 14;

	localparam logic [CFG_IDX_W-1:0] REG_CAPTURE_COUNT    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REF_ENABLE       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_TEMP_DEG     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_TEMP_READING = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_SLOPE       = 3'd4;

	typedef struct packed {
		logic [10:0]        capture_count;
		logic               ref_channel_enable;
		logic [7:0]         cal_temp_deg;
		logic [11:0]        cal_temp_reading;
		logic signed [13:0] temp_slope_uv;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		capture_count:      11'd1024,
		ref_channel_enable: 1'b0,
		cal_temp_deg:       8'd255,
		cal_temp_reading:   12'd4095,
		temp_slope_uv:      -14'sd1840
	};

	typedef struct packed {
		phase_t      channel;
		logic [11:0] sample;
		logic        capture_write;
		logic [9:0]  capture_index;
		logic        capture_done;
		phase_t      next_channel;
	} job_t;

	localparam logic [7:0]  CAL_DEG_BLANK     = 8'hFF;
	localparam logic [11:0] CAL_READING_BLANK = 12'hFFF;
	localparam logic [12:0] SAMPLE_MID        = 13'd2048;
	localparam logic [12:0] MV_FULL_SCALE     = 13'd5000;
	localparam logic [24:0] MV_ROUND          = 25'd2048;
	localparam int          MV_SHIFT          = 12;
	// 1250000 / 4096 * 256, scaled so that the quotient carries 1/16 degree.
	localparam logic signed [17:0] TEMP_GAIN  = 18'sd78125;
	localparam logic signed [15:0] TEMP_UNCAL = -16'sd4370;
	localparam logic signed [15:0] VALUE_MAX  = 16'sd32767;
	localparam logic signed [15:0] VALUE_MIN  = -16'sd32768;

	localparam int DIV_W = 32;
	localparam int DVS_W = 19;

endpackage

// ===== src/acrr_if.sv =====
// ----------------------------------------------------------------------------
// ADC round-robin converter channels
// Valid/ready channels for incoming conversion words and outgoing results.
// ----------------------------------------------------------------------------
interface acrr_in_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [11:0] adc_sample;

	modport source (output valid, op, adc_sample, input ready);
	modport sink (input valid, op, adc_sample, output ready);
endinterface

interface acrr_out_if;
	logic               valid;
	logic               ready;
	logic [2:0]         channel;
	logic signed [15:0] value;
	logic               capture_write;
	logic [9:0]         capture_index;
	logic               capture_done;
	logic               uncalibrated;
	logic [2:0]         next_channel;

	modport source (output valid, channel, value, capture_write, capture_index,
		capture_done, uncalibrated, next_channel, input ready);
	modport sink (input valid, channel, value, capture_write, capture_index,
		capture_done, uncalibrated, next_channel, output ready);
endinterface

// ===== src/adc_channel_round_robin_converter.sv =====
// ----------------------------------------------------------------------------
// ADC channel round-robin converter
// Top level: configuration registers, phase front end, job queue and
// conversion back end.
// ----------------------------------------------------------------------------
// Each word on samples is either an ADC result or an arm-capture event. The
// front end takes one word per cycle while its two-entry job queue has room;
// arm events are absorbed there and give no result. A capture, millivolt,
// uncalibrated or zero-slope temperature result passes from the head of the
// queue straight to the emit state; the back end pops a new job only while it
// is idle, so it works on one word at a time. A calibrated temperature result
// first passes through the multiply, numerator, prepare, 32-step restoring
// divider and rounding states. Results wait in an output register; while the
// sink stalls, the job queue fills and the front end then holds off new words.
module adc_channel_round_robin_converter #(
	parameter int BUF_DEPTH     = 1024,
	parameter int START_CHANNEL = 1
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [acrr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [acrr_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	acrr_in_if.sink                            samples,
	acrr_out_if.source                         results
);
	import acrr_pkg::*;

	cfg_t cfg_q;
	logic queue_full;
	logic push;
	job_t push_job;
	logic pop;
	logic queue_valid;
	job_t head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_CAPTURE_COUNT:    cfg_q.capture_count <= cfg_wdata[10:0];
				REG_REF_ENABLE:       cfg_q.ref_channel_enable <= cfg_wdata[0];
				REG_CAL_TEMP_DEG:     cfg_q.cal_temp_deg <= cfg_wdata[7:0];
				REG_CAL_TEMP_READING: cfg_q.cal_temp_reading <= cfg_wdata[11:0];
				REG_TEMP_SLOPE:       cfg_q.temp_slope_uv <= $signed(cfg_wdata);
				default: begin
				end
			endcase
		end
	end

	acrr_front #(
		.BUF_DEPTH(BUF_DEPTH),
		.START_CHANNEL(START_CHANNEL)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.samples(samples),
		.queue_full(queue_full),
		.push(push),
		.push_job(push_job)
	);

	acrr_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_job(push_job),
		.full(queue_full),
		.pop(pop),
		.not_empty(queue_valid),
		.head(head)
	);

	acrr_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.job_valid(queue_valid),
		.job(head),
		.job_pop(pop),
		.results(results)
	);

endmodule

// ===== src/acrr_front.sv =====
// ----------------------------------------------------------------------------
// ADC round-robin converter front end
// Tracks the channel phase and the capture run, and turns each conversion
// word into a job for the back end.
// ----------------------------------------------------------------------------
module acrr_front #(
	parameter int BUF_DEPTH     = 1024,
	parameter int START_CHANNEL = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  acrr_pkg::cfg_t cfg,
	acrr_in_if.sink       samples,
	input  logic          queue_full,
	output logic          push,
	output acrr_pkg::job_t push_job
);
	import acrr_pkg::*;

	localparam int PW = (BUF_DEPTH > 2) ? $clog2(BUF_DEPTH) : 1;
	localparam int CW = (PW + 1 > 11) ? PW + 1 : 11;
	localparam logic [PW:0] DEPTH_LIM = (PW + 1)'(BUF_DEPTH);

	phase_t        phase_q;
	logic          active_q;
	logic [PW-1:0] pos_q;

	logic          accept;
	logic [PW:0]   pos_next;
	logic          run_end;
	logic [31:0]   pos_ext;
	phase_t        next_phase;
	logic          known_phase;

	assign samples.ready = !queue_full;
	assign accept = samples.valid && samples.ready;

	assign pos_next = {1'b0, pos_q} + 1'b1;
	assign run_end = (CW'(pos_next) >= CW'(cfg.capture_count)) || (pos_next >= DEPTH_LIM);
	assign pos_ext = 32'(pos_q);

	always_comb begin
		known_phase = 1'b1;
		case (phase_q)
			PH_CAPTURE: next_phase = PH_TEMP;
			PH_TEMP:    next_phase = PH_SUPPLY;
			PH_SUPPLY:  next_phase = PH_CORE;
			PH_CORE:    next_phase = cfg.ref_channel_enable ? PH_REF : PH_TEMP;
			PH_REF:     next_phase = PH_CAPTURE;
			default: begin
				next_phase = PH_TEMP;
				known_phase = 1'b0;
			end
		endcase
	end

	always_comb begin
		push = accept && !samples.op && known_phase;
		push_job.channel = phase_q;
		push_job.sample = samples.adc_sample;
		push_job.capture_write = (phase_q == PH_CAPTURE) && active_q;
		push_job.capture_index = (phase_q == PH_CAPTURE && active_q) ? pos_ext[9:0] : 10'd0;
		push_job.capture_done = (phase_q == PH_CAPTURE) && active_q && run_end;
		push_job.next_channel = next_phase;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= phase_t'(3'(START_CHANNEL));
			active_q <= 1'b0;
			pos_q <= '0;
		end else if (accept) begin
			if (samples.op) begin
				active_q <= 1'b1;
			end else begin
				phase_q <= next_phase;
				if (phase_q == PH_CAPTURE && active_q) begin
					if (run_end) begin
						pos_q <= '0;
						active_q <= 1'b0;
					end else begin
						pos_q <= pos_next[PW-1:0];
					end
				end
			end
		end
	end

endmodule

// ===== src/acrr_fifo.sv =====
// ----------------------------------------------------------------------------
// ADC round-robin converter job queue
// Two-entry queue that decouples the phase logic from the conversion unit.
// ----------------------------------------------------------------------------
module acrr_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  acrr_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output acrr_pkg::job_t head
);
	import acrr_pkg::*;

	job_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== src/acrr_back.sv =====
// ----------------------------------------------------------------------------
// ADC round-robin converter back end
// Converts queued jobs into results: centred capture samples, millivolts, and
// temperature (bit-serial restoring divider when calibrated, nonzero slope).
// ----------------------------------------------------------------------------
module acrr_back (
	input  logic           clk,
	input  logic           arst_n,
	input  acrr_pkg::cfg_t cfg,
	input  logic           job_valid,
	input  acrr_pkg::job_t job,
	output logic           job_pop,
	acrr_out_if.source     results
);
	import acrr_pkg::*;

	back_state_t state_q, state_d;

	job_t               job_q;
	logic signed [15:0] val_q;
	logic               uncal_q;
	logic signed [22:0] prod_a_q;
	logic signed [30:0] prod_b_q;
	logic signed [31:0] num_q;
	logic               neg_q;
	logic [DIV_W-1:0]   dvd_q;
	logic [DVS_W-1:0]   dvs_q;
	logic [DVS_W-1:0]   rem_q;
	logic [DIV_W-1:0]   quo_q;
	logic [4:0]         cnt_q;

	logic               out_valid_q;
	logic [2:0]         out_channel_q;
	logic signed [15:0] out_value_q;
	logic               out_write_q;
	logic [9:0]         out_index_q;
	logic               out_done_q;
	logic               out_uncal_q;
	logic [2:0]         out_next_q;

	logic               out_free;
	logic               calibrated;
	logic               slope_zero;
	logic signed [15:0] simple_val;
	logic [24:0]        mv_full;
	logic signed [12:0] cal_diff;
	logic [30:0]        num_abs;
	logic [13:0]        slope_mag;
	logic [17:0]        den_abs;
	logic [DVS_W:0]     rem_sh;
	logic               rem_ge;
	logic [DVS_W:0]     rem_sub;

	assign out_free = !out_valid_q || results.ready;
	assign calibrated = (cfg.cal_temp_deg != CAL_DEG_BLANK)
		&& (cfg.cal_temp_reading != CAL_READING_BLANK);
	assign slope_zero = (cfg.temp_slope_uv == 14'sd0);

	assign mv_full = 25'(job.sample) * 25'(MV_FULL_SCALE) + MV_ROUND;

	always_comb begin
		case (job.channel)
			PH_CAPTURE: simple_val = job.capture_write ?
				16'($signed({1'b0, job.sample}) - $signed(SAMPLE_MID)) : 16'sd0;
			PH_TEMP: simple_val = calibrated ? $signed({4'd0, cfg.cal_temp_deg, 4'd0}) : TEMP_UNCAL;
			default: simple_val = $signed({3'd0, mv_full[MV_SHIFT +: 13]});
		endcase
	end

	assign cal_diff = $signed({1'b0, cfg.cal_temp_reading}) - $signed({1'b0, job_q.sample});
	assign num_abs = num_q[31] ? 31'(-num_q) : 31'(num_q);
	assign slope_mag = cfg.temp_slope_uv[13] ? 14'(-cfg.temp_slope_uv) :
		14'(cfg.temp_slope_uv);
	assign den_abs = {slope_mag, 4'd0};

	assign rem_sh = {rem_q, dvd_q[DIV_W-1]};
	assign rem_ge = rem_sh >= {1'b0, dvs_q};
	assign rem_sub = rem_sh - {1'b0, dvs_q};

	always_comb begin
		state_d = state_q;
		job_pop = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (job_valid) begin
					job_pop = 1'b1;
					if (job.channel == PH_TEMP && calibrated && !slope_zero) begin
						state_d = B_MUL;
					end else begin
						state_d = B_EMIT;
					end
				end
			end
			B_MUL:   state_d = B_NUM;
			B_NUM:   state_d = B_PREP;
			B_PREP:  state_d = B_DIV;
			B_DIV: begin
				if (cnt_q == 5'(DIV_W - 1)) begin
					state_d = B_ROUND;
				end
			end
			B_ROUND: state_d = B_EMIT;
			B_EMIT: begin
				if (out_free) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == B_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				job_q <= job;
				val_q <= simple_val;
				uncal_q <= (job.channel == PH_TEMP) && !calibrated;
			end
			B_MUL: begin
				prod_a_q <= $signed({1'b0, cfg.cal_temp_deg}) * cfg.temp_slope_uv;
				prod_b_q <= 31'(cal_diff) * 31'(TEMP_GAIN);
			end
			B_NUM: begin
				num_q <= (32'(prod_a_q) <<< 8) - 32'(prod_b_q);
			end
			B_PREP: begin
				neg_q <= num_q[31] ^ cfg.temp_slope_uv[13];
				dvd_q <= {num_abs, 1'b0} + DIV_W'(den_abs);
				dvs_q <= {den_abs, 1'b0};
				rem_q <= '0;
				quo_q <= '0;
				cnt_q <= '0;
			end
			B_DIV: begin
				rem_q <= rem_ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], rem_ge};
				dvd_q <= {dvd_q[DIV_W-2:0], 1'b0};
				cnt_q <= cnt_q + 5'd1;
			end
			B_ROUND: begin
				if (neg_q) begin
					val_q <= (quo_q > 32'd32768) ? VALUE_MIN : $signed(16'd0 - quo_q[15:0]);
				end else begin
					val_q <= (quo_q > 32'd32767) ? VALUE_MAX : $signed(quo_q[15:0]);
				end
			end
			B_EMIT: begin
				if (out_free) begin
					out_channel_q <= job_q.channel;
					out_value_q <= val_q;
					out_write_q <= job_q.capture_write;
					out_index_q <= job_q.capture_index;
					out_done_q <= job_q.capture_done;
					out_uncal_q <= uncal_q;
					out_next_q <= job_q.next_channel;
				end
			end
			default: begin
			end
		endcase
	end

	assign results.valid = out_valid_q;
	assign results.channel = out_channel_q;
	assign results.value = out_value_q;
	assign results.capture_write = out_write_q;
	assign results.capture_index = out_index_q;
	assign results.capture_done = out_done_q;
	assign results.uncalibrated = out_uncal_q;
	assign results.next_channel = out_next_q;

endmodule
